/* sv/mdag_pkg.sv */
`timescale 1ns / 1ps

package mdag_pkg;

    localparam int unsigned NUM_ARRAYS = 256;
    localparam int unsigned MAX_DIMS   = 16;

    localparam int unsigned ID_W       = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
    localparam int unsigned SLOT_DEPTH = NUM_ARRAYS * MAX_DIMS;
    localparam int unsigned SLOT_W     = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned AID_W   = 8;
    localparam int unsigned DIM_W   = 4;
    localparam int unsigned BASE_W  = 31;
    localparam int unsigned ESIZE_W = 16;
    localparam int unsigned DCNT_W  = 5;
    localparam int unsigned WORD_W  = 32;

    localparam int unsigned IN_W  = 160;
    localparam int unsigned OUT_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_HEADER = 2'd0,
        CMD_BOUNDS = 2'd1,
        CMD_INDEX  = 2'd2
    } cmd_t;

    // Packed with array_id in the lowest bits, matching the stream word layout.
    typedef struct packed {
        logic [WORD_W-1:0]  index_value;
        logic [WORD_W-1:0]  upper_bound;
        logic [WORD_W-1:0]  lower_bound;
        logic [DCNT_W-1:0]  dim_count;
        logic [ESIZE_W-1:0] element_size;
        logic [BASE_W-1:0]  base_addr;
        logic [DIM_W-1:0]   dim;
        logic [AID_W-1:0]   array_id;
    } item_t;

    typedef struct packed {
        logic take;
        logic fold;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic in_is_index;
        logic fold_ok;
        logic fold_last;
    } status_t;

endpackage

/* sv/mdag_datapath.sv */
`timescale 1ns / 1ps

module mdag_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mdag_pkg::ctrl_t           ctrl,
    output mdag_pkg::status_t         status,
    input  mdag_pkg::cmd_t            in_cmd,
    input  mdag_pkg::item_t           in_item,
    output logic [mdag_pkg::OUT_W-1:0] out_word
);
    import mdag_pkg::*;

    logic [BASE_W-1:0]  base_mem   [NUM_ARRAYS];
    logic [ESIZE_W-1:0] size_mem   [NUM_ARRAYS];
    logic [DCNT_W-1:0]  dims_mem   [NUM_ARRAYS];
    logic [WORD_W-1:0]  lower_mem  [SLOT_DEPTH];
    logic [WORD_W-1:0]  extent_mem [SLOT_DEPTH];

    logic [ID_W-1:0]   hdr_addr;
    logic [SLOT_W-1:0] slot_addr;
    logic              id_ok;
    logic              dim_ok;

    logic [BASE_W-1:0]  base_rd_reg;
    logic [ESIZE_W-1:0] size_rd_reg;
    logic [DCNT_W-1:0]  dims_rd_reg;
    logic [WORD_W-1:0]  lower_rd_reg;
    logic [WORD_W-1:0]  extent_rd_reg;

    cmd_t              cmd_reg;
    logic              id_ok_reg;
    logic [AID_W-1:0]  id_reg;
    logic [DIM_W-1:0]  dim_reg;
    logic [WORD_W-1:0] idx_reg;

    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;
    logic [WORD_W-1:0] out_addr_reg;
    logic [AID_W-1:0]  out_id_reg;

    logic [DCNT_W-1:0] eff_dims;
    logic [DCNT_W-1:0] dim_ext;
    logic [WORD_W-1:0] term;
    logic [WORD_W-1:0] fold_prod;
    logic [WORD_W-1:0] addr_prod;
    logic [WORD_W-1:0] addr_sum;

    assign hdr_addr  = ID_W'(in_item.array_id);
    assign slot_addr = SLOT_W'(32'(in_item.array_id) * MAX_DIMS + 32'(in_item.dim));
    assign id_ok     = 32'(in_item.array_id) < NUM_ARRAYS;
    assign dim_ok    = 32'(in_item.dim) < MAX_DIMS;

    always_ff @(posedge clk)
    begin
        if (ctrl.take && id_ok)
        begin
            if (in_cmd == CMD_HEADER)
            begin
                base_mem[hdr_addr] <= in_item.base_addr;
                size_mem[hdr_addr] <= in_item.element_size;
                dims_mem[hdr_addr] <= in_item.dim_count;
            end
            if (in_cmd == CMD_BOUNDS && dim_ok)
            begin
                lower_mem[slot_addr]  <= in_item.lower_bound;
                extent_mem[slot_addr] <= in_item.upper_bound - in_item.lower_bound + 32'd1;
            end
        end
        if (ctrl.take)
        begin
            base_rd_reg   <= base_mem[hdr_addr];
            size_rd_reg   <= size_mem[hdr_addr];
            dims_rd_reg   <= dims_mem[hdr_addr];
            lower_rd_reg  <= lower_mem[slot_addr];
            extent_rd_reg <= extent_mem[slot_addr];
            cmd_reg       <= in_cmd;
            id_ok_reg     <= id_ok;
            id_reg        <= in_item.array_id;
            dim_reg       <= in_item.dim;
            idx_reg       <= in_item.index_value;
        end
    end

    // A dimension count of zero acts as one, and counts beyond the limit are clipped.
    always_comb
    begin
        if (dims_rd_reg == '0)
            eff_dims = DCNT_W'(1);
        else if (32'(dims_rd_reg) > MAX_DIMS)
            eff_dims = DCNT_W'(MAX_DIMS);
        else
            eff_dims = dims_rd_reg;
    end

    assign dim_ext   = DCNT_W'(dim_reg);
    assign term      = idx_reg - lower_rd_reg;
    assign fold_prod = acc_reg * extent_rd_reg;
    assign addr_prod = acc_reg * WORD_W'(size_rd_reg);
    assign addr_sum  = WORD_W'(base_rd_reg) + addr_prod;

    assign status.in_is_index = (in_cmd == CMD_INDEX);
    assign status.fold_ok     = (cmd_reg == CMD_INDEX) && id_ok_reg && (dim_ext < eff_dims);
    assign status.fold_last   = (dim_ext + DCNT_W'(1)) == eff_dims;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.emit)
            acc_next = '0;
        else if (ctrl.fold)
            acc_next = (dim_reg == '0) ? term : fold_prod + term;
        else if (ctrl.take && id_ok && in_cmd == CMD_HEADER)
            acc_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            out_addr_reg <= addr_sum;
            out_id_reg   <= id_reg;
        end
    end

    assign out_word = {out_id_reg, out_addr_reg};

endmodule

/* sv/mdag_ctrl.sv */
`timescale 1ns / 1ps

module mdag_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  mdag_pkg::status_t status,
    output mdag_pkg::ctrl_t   ctrl
);
    import mdag_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_ADDR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;

    assign ctrl.take = s_tvalid && (state_reg == ST_IDLE);
    assign ctrl.fold = (state_reg == ST_FOLD) && status.fold_ok;
    // The address word loads only once the output register is free or being drained.
    assign ctrl.emit = (state_reg == ST_ADDR) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.take && status.in_is_index)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                if (status.fold_ok && status.fold_last)
                    state_next = ST_ADDR;
                else
                    state_next = ST_IDLE;
            end
            ST_ADDR:
            begin
                if (ctrl.emit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ctrl.emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* sv/multi_dim_array_address_gen_unit.sv */
`timescale 1ns / 1ps

// Channel   Direction  Word                                    Handshake
// s_*       in         header, bounds or index word (tuser)    s_tvalid / s_tready
// m_*       out        element address and array id            m_tvalid / m_tready
//
// A header or bounds word is written to the tables at acceptance.
// An index word passes through the registered table read, then the fold multiply-add.
// The final index of a reference adds the address multiply step, plus any wait
// for the output register to empty.
// Reset clears the controller and the accumulator only; the tables hold nothing
// defined until written, so there is no clearing pass.

module multi_dim_array_address_gen_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // array_id, dim, base_addr, element_size, dim_count, lower_bound, upper_bound,
    // index_value
    input  logic [mdag_pkg::IN_W-1:0]  s_tdata,
    // command
    input  logic [mdag_pkg::CMD_W-1:0] s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // address, result_array_id
    output logic [mdag_pkg::OUT_W-1:0] m_tdata
);
    import mdag_pkg::*;

    item_t   in_item;
    cmd_t    in_cmd;
    ctrl_t   ctrl;
    status_t status;

    assign in_item = item_t'(s_tdata);
    assign in_cmd  = cmd_t'(s_tuser);

    mdag_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    mdag_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .status   (status),
        .in_cmd   (in_cmd),
        .in_item  (in_item),
        .out_word (m_tdata)
    );

endmodule

/* sv/mdag_checker.sv */
`timescale 1ns / 1ps

module mdag_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [mdag_pkg::CMD_W-1:0] s_tuser,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [mdag_pkg::OUT_W-1:0] m_tdata
);
    import mdag_pkg::*;

    // An index word always occupies the fold step, so input must close while it is folded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == CMD_INDEX) |=> !s_tready)
        else $error("input still open right after an index word");

    // No address can appear in the cycle after acceptance: the table read comes first.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result word appeared too early");

    // A new result word is only produced out of the address step, when input is closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result word produced while input was open");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

endmodule

bind multi_dim_array_address_gen_unit mdag_checker u_mdag_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import mdag_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned      WATCHDOG_LIMIT = 3000;
    localparam int unsigned      LONG_HOLD = 300;
    localparam int unsigned      RANDOM_WORDS = 1750;
    localparam int unsigned      QUIET_TAIL = 250;

    // Predicts element addresses from the declared array tables and checks them.
    class addr_scoreboard;
        typedef struct {
            bit [WORD_W-1:0] address;
            bit [AID_W-1:0]  array_id;
        } addr_result_t;

        bit [WORD_W-1:0]  base_tab [NUM_ARRAYS];
        bit [ESIZE_W-1:0] size_tab [NUM_ARRAYS];
        bit [DCNT_W-1:0]  dims_tab [NUM_ARRAYS];
        bit [WORD_W-1:0]  lower_tab [SLOT_DEPTH];
        bit [WORD_W-1:0]  extent_tab [SLOT_DEPTH];
        bit               bounds_seen [SLOT_DEPTH];
        bit [WORD_W-1:0]  acc;
        addr_result_t     pending_q [$];
        int               errors;

        function int unsigned dims_in_use(int unsigned id);
            int unsigned d;
            d = dims_tab[id];
            if (d == 0)
                d = 1;
            if (d > MAX_DIMS)
                d = MAX_DIMS;
            return d;
        endfunction

        function int unsigned outstanding();
            return pending_q.size();
        endfunction

        function void note_word(logic [CMD_W-1:0] cmd, item_t w);
            int unsigned  id;
            int unsigned  slot;
            int unsigned  nd;
            bit [WORD_W-1:0] term;
            addr_result_t r;
            id = w.array_id;
            slot = id * MAX_DIMS + w.dim;
            case (cmd)
                CMD_HEADER:
                begin
                    base_tab[id] = {1'b0, w.base_addr};
                    size_tab[id] = w.element_size;
                    dims_tab[id] = w.dim_count;
                    acc = '0;
                end
                CMD_BOUNDS:
                begin
                    if (w.dim < MAX_DIMS)
                    begin
                        lower_tab[slot] = w.lower_bound;
                        extent_tab[slot] = w.upper_bound - w.lower_bound + 32'd1;
                        bounds_seen[slot] = 1'b1;
                    end
                end
                CMD_INDEX:
                begin
                    nd = dims_in_use(id);
                    if (w.dim < nd)
                    begin
                        term = w.index_value - lower_tab[slot];
                        if (w.dim == 0)
                            acc = term;
                        else
                            acc = acc * extent_tab[slot] + term;
                        if (w.dim + 1 == nd)
                        begin
                            r.address = base_tab[id] + acc * {16'd0, size_tab[id]};
                            r.array_id = AID_W'(id);
                            pending_q = {pending_q, r};
                            acc = '0;
                        end
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            addr_result_t want;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected word: address %h, array id %0d",
                         $time, data[31:0], data[39:32]);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (data[31:0] !== want.address)
            begin
                $display("%0t: address mismatch: expected %h, actual %h",
                         $time, want.address, data[31:0]);
                errors++;
            end
            if (data[39:32] !== want.array_id)
            begin
                $display("%0t: array id mismatch: expected %0d, actual %0d",
                         $time, want.array_id, data[39:32]);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic [CMD_W-1:0] s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    addr_scoreboard sb = new;
    int unsigned    n_sent;
    int unsigned    tx_idle_pct;
    bit             calm;
    bit             hold_req;
    int unsigned    ready_ids [$];

    multi_dim_array_address_gen_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic item_t noise_item();
        item_t w;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return w;
    endfunction

    // Valid stays high between back-to-back words; this task drops it only for a gap.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input item_t w);
        int unsigned gap;
        if (!calm && $urandom_range(0, 99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        s_tuser <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_word(cmd, w);
        n_sent++;
        if ($urandom_range(0, 63) == 0)
            tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 45);
    endtask

    task automatic send_header(input int unsigned id, input bit [31:0] base,
                               input int unsigned size, input int unsigned dc);
        item_t w;
        w = noise_item();
        w.array_id = AID_W'(id);
        w.base_addr = base[30:0];
        w.element_size = ESIZE_W'(size);
        w.dim_count = DCNT_W'(dc);
        send_word(CMD_HEADER, w);
    endtask

    task automatic send_bounds(input int unsigned id, input int unsigned d,
                               input bit [31:0] lo, input bit [31:0] hi);
        item_t w;
        w = noise_item();
        w.array_id = AID_W'(id);
        w.dim = DIM_W'(d);
        w.lower_bound = lo;
        w.upper_bound = hi;
        send_word(CMD_BOUNDS, w);
    endtask

    task automatic send_index(input int unsigned id, input int unsigned d,
                              input bit [31:0] idx);
        item_t w;
        w = noise_item();
        w.array_id = AID_W'(id);
        w.dim = DIM_W'(d);
        w.index_value = idx;
        send_word(CMD_INDEX, w);
    endtask

    task automatic send_random_bounds(input int unsigned id, input int unsigned d);
        bit [31:0] lo;
        bit [31:0] hi;
        lo = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 40) - 20;
        hi = ($urandom_range(0, 4) == 0) ? $urandom : lo + $urandom_range(0, 12);
        send_bounds(id, d, lo, hi);
    endtask

    // Mostly in range, now and then any value at all.
    function automatic bit [31:0] pick_index(int unsigned id, int unsigned d);
        int unsigned slot;
        bit [31:0]   span;
        slot = id * MAX_DIMS + d;
        span = sb.extent_tab[slot];
        if (span == 0 || $urandom_range(0, 9) == 0)
            return $urandom;
        return sb.lower_tab[slot] + ($urandom % span);
    endfunction

    // Here a header is always followed by bounds for every dimension in use,
    // so every id in the ready list can be referenced in full.
    task automatic define_array(input int unsigned id);
        int unsigned r;
        int unsigned dc;
        int unsigned nd;
        r = $urandom_range(0, 19);
        if (r == 0)
            dc = 0;
        else if (r == 1)
            dc = $urandom_range(MAX_DIMS + 1, 31);
        else if (r < 5)
            dc = $urandom_range(5, MAX_DIMS);
        else
            dc = $urandom_range(1, 4);
        send_header(id, $urandom,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(1, 64), dc);
        nd = sb.dims_in_use(id);
        for (int unsigned d = 0; d < nd; d++)
            send_random_bounds(id, d);
        if (nd < MAX_DIMS && $urandom_range(0, 2) == 0)
            send_random_bounds(id, $urandom_range(nd, MAX_DIMS - 1));
        foreach (ready_ids[i])
            if (ready_ids[i] == id)
                return;
        ready_ids = {ready_ids, id};
    endtask

    task automatic send_reference(input int unsigned id, input int unsigned upto);
        for (int unsigned d = 0; d < upto; d++)
            send_index(id, d, pick_index(id, d));
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // Receiver: checks each accepted word and throttles m_tready.
    initial
    begin
        int unsigned stall;
        int unsigned hold;
        int unsigned rx_idle_pct;
        stall = 0;
        hold = 0;
        rx_idle_pct = 20;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ($urandom_range(0, 127) == 0)
                rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold = LONG_HOLD;
                m_tready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < rx_idle_pct)
            begin
                stall = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int unsigned idle;
        idle = 0;
        wait (rst_n === 1'b1);
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        int unsigned target;
        int unsigned pick;
        int unsigned id;
        int unsigned d;
        int unsigned nd;
        bit          hold_done;
        bit          drain_done;
        item_t       w;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_HEADER;
        n_sent = 0;
        tx_idle_pct = 20;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        drain_done = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-range bounds give an extent of zero; the offset wraps to all ones.
        send_header(0, 32'h0, 1, 1);
        send_bounds(0, 0, 32'h8000_0000, 32'h7fff_ffff);
        send_index(0, 0, 32'h7fff_ffff);
        // A dimension count of zero acts as one dimension.
        send_header(255, 32'h7fff_ffff, 16'hffff, 0);
        send_bounds(255, 0, 32'd5, 32'd5);
        send_bounds(255, MAX_DIMS - 1, 32'hffff_ffff, 32'h0);
        send_index(255, 0, 32'h8000_0000);
        send_index(255, MAX_DIMS - 1, 32'h0);
        // Count 31 is clamped to the maximum; only the first and last dims are used.
        send_header(7, 32'h2aaa_aaaa, 16'h5555, 31);
        send_bounds(7, 0, -32'sd3, 32'd4);
        send_bounds(7, MAX_DIMS - 1, 32'd100, 32'd0);
        send_index(7, 0, 32'd1);
        send_index(7, 0, -32'sd3);
        send_index(7, MAX_DIMS - 1, 32'd50);
        // A header in the middle of a reference clears the running sum.
        send_index(7, 0, 32'd2);
        send_header(0, 32'h5555_5555, 16'haaaa, 1);
        send_index(7, MAX_DIMS - 1, 32'hffff_ffff);
        // Another array's reference in between also leaves the sum at zero.
        send_index(7, 0, 32'd4);
        send_index(0, 0, 32'd0);
        send_index(7, MAX_DIMS - 1, 32'd7);
        w = noise_item();
        w.array_id = 0;
        w.dim = 0;
        send_word(CMD_UNUSED, w);
        send_header(1, 32'h1234_5678, 0, 2);
        send_bounds(1, 0, 32'd0, 32'd9);
        send_bounds(1, 1, 32'd1, 32'd3);
        send_reference(1, 2);
        ready_ids = {ready_ids, 32'd0};
        ready_ids = {ready_ids, 32'd255};
        ready_ids = {ready_ids, 32'd1};

        target = n_sent + RANDOM_WORDS;
        while (n_sent < target)
        begin
            if (n_sent + QUIET_TAIL >= target)
                calm = 1'b1;
            if (!hold_done && n_sent >= 600)
            begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && n_sent >= 1100)
            begin
                wait_for_results();
                drain_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            id = ready_ids[$urandom_range(0, ready_ids.size() - 1)];
            nd = sb.dims_in_use(id);
            if (ready_ids.size() < 4 || pick < 6)
                define_array($urandom_range(0, NUM_ARRAYS - 1));
            else if (pick < 80)
                send_reference(id, nd);
            else if (pick < 86)
                send_reference(id, (nd > 1) ? $urandom_range(1, nd - 1) : 1);
            else if (pick < 92)
            begin
                // Lone index, possibly beyond the declared dimension count.
                d = $urandom_range(0, MAX_DIMS - 1);
                if (!sb.bounds_seen[id * MAX_DIMS + d])
                    d = 0;
                send_index(id, d, pick_index(id, d));
            end
            else if (pick < 96)
                send_random_bounds(id, $urandom_range(0, MAX_DIMS - 1));
            else
            begin
                w = noise_item();
                w.array_id = AID_W'(id);
                w.dim = 0;
                send_word(CMD_UNUSED, w);
            end
        end

        wait_for_results();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

/* files.f */
sv/mdag_pkg.sv
sv/mdag_datapath.sv
sv/mdag_ctrl.sv
sv/multi_dim_array_address_gen_unit.sv
sv/mdag_checker.sv
tb/sv/tb_top.sv
